// File: rtl/bplru_pkg.sv
// Shared types and constants of the buffer-pool page table.
package bplru_pkg;

    localparam int FRAMES_DEF = 8;
    localparam int PAGE_W     = 16;
    localparam int PINS_W     = 8;
    localparam int AGE_W      = 8;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int FIDX_W     = 3;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNPIN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOGGLE  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOADED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EVICT_CLEAN = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EVICT_DIRTY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALL_PINNED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ABSENT      = 3'd5;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_APPLY,
        S_OUT
    } ctrl_state_t;

    // Datapath operations
    typedef enum logic [2:0] {
        DP_HOLD,
        DP_LATCH,
        DP_SCAN,
        DP_DECIDE,
        DP_APPLY
    } dp_op_t;

    // Change applied to the target frame
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_PIN,
        ACT_UNPIN,
        ACT_TOGGLE,
        ACT_LOAD
    } act_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic need_apply;
    } dp_stat_t;

endpackage

// File: rtl/buffer_pool_lru_page_table_top.sv
// Top level of the buffer-pool page table with LRU replacement and pin counts.
//
// Usage: one transaction on the slave side carries a kind (tuser) and a page id
// (tdata); exactly one result transaction follows on the master side with the
// frame index, a status code (tuser) and the evicted page id.
// Each transaction is served in full before the next is taken: s_tready is
// high only while the block is idle.
// The frame table rotates past a single head entry once to search (hit, first
// empty, oldest unpinned frame) and, only when the table changes (pin, unpin,
// toggle, load), once more to write the change and, for a request, advance
// the ages. m_tvalid rises in the output state, which follows the decide step
// directly when the table does not change.
// Reset (aresetn low, synchronous) empties every frame and clears dirty bits,
// pin counts and ages; no clearing pass is needed afterwards.
// A stalled receiver holds the result steady until m_tready; no new request
// is taken meanwhile.
module buffer_pool_lru_page_table_top import bplru_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] page_id
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] frame_index, [18:3] evicted_page, rest zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int IDX_W = $clog2(FRAMES);

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [IDX_W-1:0]    pos;
    logic [IDX_W-1:0]    res_frame;
    logic [STATUS_W-1:0] res_status;
    logic [PAGE_W-1:0]   res_evicted;
    logic [IDX_W+FIDX_W-1:0] frame_ext;

    bplru_ctrl #(.FRAMES(FRAMES)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .pos      (pos),
        .stat     (stat)
    );

    bplru_dp #(.FRAMES(FRAMES)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .pos         (pos),
        .stat        (stat),
        .in_kind     (s_tuser),
        .in_page     (s_tdata),
        .res_frame   (res_frame),
        .res_status  (res_status),
        .res_evicted (res_evicted)
    );

    // Keep the low three bits of the frame index
    assign frame_ext = {{FIDX_W{1'b0}}, res_frame};
    assign m_tdata   = {5'd0, res_evicted, frame_ext[FIDX_W-1:0]};
    assign m_tuser   = res_status;

endmodule

// File: rtl/bplru_ctrl.sv
// Controller state machine sequencing latch, scan, decide, apply and output.
module bplru_ctrl import bplru_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF,
    localparam int IDX_W = $clog2(FRAMES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output dp_cmd_t          cmd,
    output logic [IDX_W-1:0] pos,
    input  dp_stat_t         stat
);

    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(FRAMES - 1);

    ctrl_state_t      state_reg, state_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             at_last;

    assign at_last = (pos_reg == LAST_POS);
    assign pos     = pos_reg;

    // Hold state and frame position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_SCAN;
            end
            S_SCAN: begin
                if (at_last) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                state_next = stat.need_apply ? S_APPLY : S_OUT;
            end
            S_APPLY: begin
                if (at_last) state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and position counter
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        cmd.op   = DP_HOLD;
        pos_next = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = DP_LATCH;
            end
            S_SCAN: begin
                cmd.op   = DP_SCAN;
                pos_next = at_last ? '0 : pos_reg + 1'b1;
            end
            S_DECIDE: begin
                cmd.op = DP_DECIDE;
            end
            S_APPLY: begin
                cmd.op   = DP_APPLY;
                pos_next = at_last ? '0 : pos_reg + 1'b1;
            end
            S_OUT: begin
                m_tvalid = 1'b1;
            end
            default: cmd.op = DP_HOLD;
        endcase
    end

endmodule

// File: rtl/bplru_dp.sv
// Datapath: rotating frame table, scan trackers, decision and result registers.
module bplru_dp import bplru_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF,
    localparam int IDX_W = $clog2(FRAMES)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    input  logic [IDX_W-1:0]    pos,
    output dp_stat_t            stat,
    input  logic [KIND_W-1:0]   in_kind,
    input  logic [PAGE_W-1:0]   in_page,
    output logic [IDX_W-1:0]    res_frame,
    output logic [STATUS_W-1:0] res_status,
    output logic [PAGE_W-1:0]   res_evicted
);

    localparam logic [PINS_W-1:0] PINS_MAX = '1;
    localparam logic [AGE_W-1:0]  AGE_MAX  = '1;

    // Frame table; entry 0 is the head that the scan and apply passes see
    logic [PAGE_W-1:0] page_reg  [FRAMES];
    logic              dirty_reg [FRAMES];
    logic [PINS_W-1:0] pins_reg  [FRAMES];
    logic [AGE_W-1:0]  age_reg   [FRAMES];

    // Request
    logic [KIND_W-1:0] kind_reg;
    logic [PAGE_W-1:0] req_page_reg;

    // Scan trackers
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              empty_reg;
    logic [IDX_W-1:0]  empty_idx_reg;
    logic              vic_reg;
    logic [IDX_W-1:0]  vic_idx_reg;
    logic [AGE_W-1:0]  vic_age_reg;
    logic [PAGE_W-1:0] vic_page_reg;
    logic              vic_dirty_reg;

    // Decided action
    act_t              act_reg, act_next;
    logic              touch_reg, touch_next;
    logic [IDX_W-1:0]  tgt_reg, tgt_next;
    logic [STATUS_W-1:0] status_next;
    logic [PAGE_W-1:0]   evicted_next;

    // Head after the apply step
    logic [PAGE_W-1:0] head_page;
    logic              head_dirty;
    logic [PINS_W-1:0] head_pins;
    logic [AGE_W-1:0]  head_age;
    logic              is_tgt;

    // Decide from the scan result
    always_comb begin
        act_next     = ACT_NONE;
        touch_next   = 1'b0;
        tgt_next     = '0;
        status_next  = ST_ABSENT;
        evicted_next = '0;
        if (req_page_reg != '0) begin
            priority if (kind_reg == KIND_UNPIN || kind_reg == KIND_TOGGLE) begin
                if (hit_reg) begin
                    act_next    = (kind_reg == KIND_UNPIN) ? ACT_UNPIN : ACT_TOGGLE;
                    tgt_next    = hit_idx_reg;
                    status_next = ST_HIT;
                end
            end else if (kind_reg == KIND_REQUEST) begin
                priority if (hit_reg) begin
                    act_next    = ACT_PIN;
                    touch_next  = 1'b1;
                    tgt_next    = hit_idx_reg;
                    status_next = ST_HIT;
                end else if (empty_reg) begin
                    act_next    = ACT_LOAD;
                    touch_next  = 1'b1;
                    tgt_next    = empty_idx_reg;
                    status_next = ST_LOADED;
                end else if (vic_reg) begin
                    act_next     = ACT_LOAD;
                    touch_next   = 1'b1;
                    tgt_next     = vic_idx_reg;
                    status_next  = vic_dirty_reg ? ST_EVICT_DIRTY : ST_EVICT_CLEAN;
                    evicted_next = vic_page_reg;
                end else begin
                    status_next = ST_ALL_PINNED;
                end
            end else begin
                status_next = ST_ABSENT;
            end
        end
    end

    assign stat.need_apply = (act_next != ACT_NONE);

    // Apply the decided change to the head entry
    always_comb begin
        head_page  = page_reg[0];
        head_dirty = dirty_reg[0];
        head_pins  = pins_reg[0];
        head_age   = age_reg[0];
        is_tgt     = (pos == tgt_reg);
        if (cmd.op == DP_APPLY) begin
            if (is_tgt) begin
                unique case (act_reg)
                    ACT_PIN: begin
                        if (pins_reg[0] != PINS_MAX) head_pins = pins_reg[0] + 1'b1;
                    end
                    ACT_UNPIN: begin
                        if (pins_reg[0] != '0) head_pins = pins_reg[0] - 1'b1;
                    end
                    ACT_TOGGLE: head_dirty = ~dirty_reg[0];
                    ACT_LOAD: begin
                        head_page  = req_page_reg;
                        head_dirty = 1'b0;
                        head_pins  = PINS_W'(1);
                    end
                    default: head_pins = pins_reg[0];
                endcase
            end
            if (touch_reg) begin
                if (is_tgt) head_age = '0;
                else if (age_reg[0] != AGE_MAX) head_age = age_reg[0] + 1'b1;
            end
        end
    end

    // Rotate the frame table during scan and apply passes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FRAMES; i++) begin
                page_reg[i]  <= '0;
                dirty_reg[i] <= 1'b0;
                pins_reg[i]  <= '0;
                age_reg[i]   <= '0;
            end
        end else if (cmd.op == DP_SCAN || cmd.op == DP_APPLY) begin
            for (int i = 0; i < FRAMES - 1; i++) begin
                page_reg[i]  <= page_reg[i+1];
                dirty_reg[i] <= dirty_reg[i+1];
                pins_reg[i]  <= pins_reg[i+1];
                age_reg[i]   <= age_reg[i+1];
            end
            page_reg[FRAMES-1]  <= head_page;
            dirty_reg[FRAMES-1] <= head_dirty;
            pins_reg[FRAMES-1]  <= head_pins;
            age_reg[FRAMES-1]   <= head_age;
        end
    end

    // Latch the request and track hit, first empty and oldest unpinned frame
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_LATCH) begin
            kind_reg     <= in_kind;
            req_page_reg <= in_page;
            hit_reg      <= 1'b0;
            empty_reg    <= 1'b0;
            vic_reg      <= 1'b0;
        end else if (cmd.op == DP_SCAN) begin
            if (!hit_reg && page_reg[0] == req_page_reg && req_page_reg != '0) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= pos;
            end
            if (!empty_reg && page_reg[0] == '0) begin
                empty_reg     <= 1'b1;
                empty_idx_reg <= pos;
            end
            if (pins_reg[0] == '0 && (!vic_reg || age_reg[0] > vic_age_reg)) begin
                vic_reg       <= 1'b1;
                vic_idx_reg   <= pos;
                vic_age_reg   <= age_reg[0];
                vic_page_reg  <= page_reg[0];
                vic_dirty_reg <= dirty_reg[0];
            end
        end
    end

    // Register the decision and the result fields
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_DECIDE) begin
            act_reg     <= act_next;
            touch_reg   <= touch_next;
            tgt_reg     <= tgt_next;
            res_frame   <= tgt_next;
            res_status  <= status_next;
            res_evicted <= evicted_next;
        end
    end

endmodule
